// File: rtl/sird_pkg.sv
// ----------------------------------------------------------------------------
// sird_pkg
// Shared types, constants and the microcode program for the radix digit
// converter.
// ----------------------------------------------------------------------------
package sird_pkg;

  localparam int MaxSymbols = 16;
  localparam int MaxDigits  = 32;
  localparam int ChunkBits  = 8;
  localparam int Chunks     = 32 / ChunkBits;

  localparam logic [7:0] PlusChar  = 8'd43;
  localparam logic [7:0] MinusChar = 8'd45;
  localparam logic [4:0] MinRadix  = 5'd2;

  localparam logic [4:0]  BaseLengthReset  = 5'd10;
  localparam logic [63:0] SymbolsLowReset  = 64'd3978425819141910832;
  localparam logic [63:0] SymbolsHighReset = 64'd14648;

  // Configuration register indexes.
  localparam logic [1:0] RegBaseLength  = 2'd0;
  localparam logic [1:0] RegSymbolsLow  = 2'd1;
  localparam logic [1:0] RegSymbolsHigh = 2'd2;

  typedef logic [2:0] upc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_SIGN,
    OP_DIGIT
  } op_t;

  typedef enum logic [2:0] {
    J_NEXT,
    J_ALWAYS,
    J_BAD_BASE,
    J_DIV_LOOP,
    J_MORE_DIGITS
  } jcond_t;

  typedef struct packed {
    op_t    op;
    jcond_t jcond;
    upc_t   target;
  } ctrl_word_t;

  localparam upc_t UpcLoad  = 3'd0;
  localparam upc_t UpcCheck = 3'd1;
  localparam upc_t UpcDiv   = 3'd2;
  localparam upc_t UpcSign  = 3'd3;
  localparam upc_t UpcDigit = 3'd4;
  localparam upc_t UpcDone  = 3'd5;

  // Control store: one word per step.
  function automatic ctrl_word_t ucode_rom(input upc_t upc);
    ctrl_word_t cw;
    cw = '{op: OP_NOP, jcond: J_ALWAYS, target: UpcLoad};
    unique case (upc)
      UpcLoad:  cw = '{op: OP_LOAD,  jcond: J_NEXT,        target: UpcLoad};
      UpcCheck: cw = '{op: OP_NOP,   jcond: J_BAD_BASE,    target: UpcLoad};
      UpcDiv:   cw = '{op: OP_DIV,   jcond: J_DIV_LOOP,    target: UpcDiv};
      UpcSign:  cw = '{op: OP_SIGN,  jcond: J_NEXT,        target: UpcLoad};
      UpcDigit: cw = '{op: OP_DIGIT, jcond: J_MORE_DIGITS, target: UpcDigit};
      UpcDone:  cw = '{op: OP_NOP,   jcond: J_ALWAYS,      target: UpcLoad};
      default:  cw = '{op: OP_NOP,   jcond: J_ALWAYS,      target: UpcLoad};
    endcase
    return cw;
  endfunction

  function automatic logic [7:0] symbol_at(input logic [127:0] symbols,
                                           input logic [3:0] idx);
    return symbols[{idx, 3'b000} +: 8];
  endfunction

  // A base is usable when it has 2 to 16 distinct symbols, none of them a sign.
  function automatic logic base_ok(input logic [4:0] len, input logic [127:0] symbols);
    logic ok;
    logic [7:0] si;
    ok = (len >= MinRadix) && (len <= 5'(MaxSymbols));
    for (int i = 0; i < MaxSymbols; i++) begin
      si = symbol_at(symbols, 4'(i));
      if (5'(i) < len) begin
        if (si == PlusChar || si == MinusChar) begin
          ok = 1'b0;
        end
        for (int j = 0; j < i; j++) begin
          if (symbol_at(symbols, 4'(j)) == si) begin
            ok = 1'b0;
          end
        end
      end
    end
    return ok;
  endfunction

endpackage

// File: rtl/signed_integer_to_radix_digits.sv
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits
// Converts a signed 32-bit value to its text in a configured radix of 2 to 16
// symbols, one character per output beat, most significant digit first.
// ----------------------------------------------------------------------------
// Steps: accept the value, check the base, divide by the radix for each digit,
// emit a minus sign for a negative value, send each character, then return.
// Throughput: one value at a time; a new value is accepted only after the last
// character of the previous one has been sent.
// The divider retires 8 quotient bits per cycle, which sets the digit rate.
// Reset restores the decimal base "0123456789", idles the sequencer and
// holds off the input and configuration channels.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_digits
  import sird_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] value,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         character,
  output logic               last,
  // Configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  // Configuration registers.
  logic [4:0]  base_length;
  logic [63:0] symbols_low;
  logic [63:0] symbols_high;
  logic [127:0] symbols;
  logic        base_valid;

  // Sequencer.
  upc_t       upc;
  upc_t       upc_next;
  ctrl_word_t cw;
  logic       hold;
  logic       jump;

  // Datapath.
  logic [31:0] mag;
  logic [31:0] mag_next;
  logic [3:0]  rem;
  logic [3:0]  rem_next;
  logic [1:0]  chunk;
  logic        neg;
  logic [5:0]  cnt;
  logic [3:0]  digit_store [MaxDigits];
  logic [3:0]  digit_rd;

  logic in_accept;
  logic out_free;
  logic emitting;
  logic last_chunk;

  // A write during reset would be lost, so the channel is held off then.
  assign cfg_ready = !rst;
  assign symbols   = {symbols_high, symbols_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length  <= BaseLengthReset;
      symbols_low  <= SymbolsLowReset;
      symbols_high <= SymbolsHighReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegBaseLength:  base_length  <= cfg_data[4:0];
        RegSymbolsLow:  symbols_low  <= cfg_data;
        RegSymbolsHigh: symbols_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // The base check is registered. The user must change configuration only while
  // idle (the block does not enforce this), so the check step reads a settled value.
  always_ff @(posedge clk) begin
    base_valid <= base_ok(base_length, symbols);
  end

  // The control word for the current step comes straight from the program.
  assign cw = ucode_rom(upc);

  // The input only opens in the load step, and never during reset.
  assign in_stall   = rst || (cw.op != OP_LOAD);
  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign emitting   = (cw.op == OP_DIGIT) || (cw.op == OP_SIGN && neg);
  assign last_chunk = (chunk == 2'(Chunks - 1));

  // A step holds while it waits for an input beat or for room at the output.
  assign hold = (cw.op == OP_LOAD && !in_accept) || (emitting && !out_free);

  // Division by the radix, eight quotient bits per cycle, most significant
  // first. The remainder stays below the radix, so four bits hold it.
  always_comb begin
    logic [4:0] r;
    logic [ChunkBits-1:0] q;
    r = {1'b0, rem};
    q = '0;
    for (int b = 0; b < ChunkBits; b++) begin
      r = {r[3:0], mag[31 - b]};
      if (r >= base_length) begin
        r = r - base_length;
        q[ChunkBits - 1 - b] = 1'b1;
      end
    end
    rem_next = r[3:0];
    mag_next = {mag[31-ChunkBits:0], q};
  end

  always_comb begin
    jump = 1'b0;
    unique case (cw.jcond)
      J_NEXT:        jump = 1'b0;
      J_ALWAYS:      jump = 1'b1;
      J_BAD_BASE:    jump = !base_valid;
      J_DIV_LOOP:    jump = !last_chunk || (mag_next != '0 && cnt != 6'(MaxDigits - 1));
      J_MORE_DIGITS: jump = (cnt != 6'd1);
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_next = upc;
    end else if (jump) begin
      upc_next = cw.target;
    end else begin
      upc_next = upc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= UpcLoad;
    end else begin
      upc <= upc_next;
    end
  end

  // Datapath registers under control of the current step.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (!hold) begin
      case (cw.op)
        OP_LOAD: begin
          cnt <= '0;
        end
        OP_DIV: begin
          if (last_chunk) begin
            cnt <= cnt + 6'd1;
          end
        end
        OP_DIGIT: begin
          cnt <= cnt - 6'd1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!hold) begin
      case (cw.op)
        OP_LOAD: begin
          neg   <= value[31];
          mag   <= value[31] ? (~value + 32'd1) : value;
          rem   <= '0;
          chunk <= '0;
        end
        OP_DIV: begin
          mag   <= mag_next;
          chunk <= chunk + 2'd1;
          rem   <= last_chunk ? 4'd0 : rem_next;
          if (last_chunk) begin
            digit_store[cnt[4:0]] <= rem_next;
          end
        end
        default: ;
      endcase
    end
  end

  // Digits were stored least significant first; they leave in reverse.
  assign digit_rd = digit_store[5'(cnt - 6'd1)];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emitting && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emitting && out_free) begin
      if (cw.op == OP_SIGN) begin
        character <= MinusChar;
        last      <= 1'b0;
      end else begin
        character <= symbol_at(symbols, digit_rd);
        last      <= (cnt == 6'd1);
      end
    end
  end

endmodule
